[rtl/multichannel_pulse_flash_output_assert.svh]
// Assertion macros for the output controller.
`ifndef MULTICHANNEL_PULSE_FLASH_OUTPUT_ASSERT_SVH
`define MULTICHANNEL_PULSE_FLASH_OUTPUT_ASSERT_SVH
`ifndef SYNTH
`define MPFO_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("assertion failed");
`define MPFO_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define MPFO_ASSERT_IMP(label, clk, rst_n, a, c)
`define MPFO_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

[rtl/mpfo_pkg.sv]
`timescale 1ns / 1ps
package mpfo_pkg;
    localparam int CHANNELS_DEF = 16;
    localparam int CH_W = 4;

    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_RESTORE = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;
    localparam logic [1:0] CMD_LOAD    = 2'd3;

    localparam logic [1:0] ACT_ON    = 2'd0;
    localparam logic [1:0] ACT_OFF   = 2'd1;
    localparam logic [1:0] ACT_FLASH = 2'd2;

    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_RESTORE = 3'd1;
    localparam logic [2:0] OP_TICK    = 3'd2;
    localparam logic [2:0] OP_LOAD    = 3'd3;
    localparam logic [2:0] OP_NOP     = 3'd4;

    typedef struct packed {
        logic       is_output;
        logic       trigger_inv;
        logic       pin_inv;
        logic       event_inv;
        logic       no_off_event;
        logic [7:0] pulse_len;
        logic [6:0] flash_half;
    } t_cfg;

    typedef struct packed {
        logic [2:0]      op;
        logic [CH_W-1:0] ch;
        logic [1:0]      action;
        t_cfg            cfg;
    } t_job;

    typedef struct packed {
        logic            ev;
        logic [CH_W-1:0] ch;
        logic            on;
        logic            done;
        logic            pv;
        logic [1:0]      pa;
    } t_rec;
endpackage

[rtl/mpfo_if.sv]
`timescale 1ns / 1ps
interface mpfo_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [3:0] channel;
    logic [1:0] action;
    logic       set_is_output;
    logic       set_trigger_inv;
    logic       set_pin_inv;
    logic       set_event_inv;
    logic       set_no_off_event;
    logic [7:0] set_pulse_len;
    logic [6:0] set_flash_half;
    modport source (output valid, cmd, channel, action, set_is_output, set_trigger_inv,
                    set_pin_inv, set_event_inv, set_no_off_event, set_pulse_len,
                    set_flash_half, input ready);
    modport sink (input valid, cmd, channel, action, set_is_output, set_trigger_inv,
                  set_pin_inv, set_event_inv, set_no_off_event, set_pulse_len,
                  set_flash_half, output ready);
endinterface

interface mpfo_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pin_levels;
    logic        event_valid;
    logic [3:0]  event_channel;
    logic        event_on;
    logic        pulse_done;
    logic        persist_valid;
    logic [1:0]  persist_action;
    logic        last;
    modport source (output valid, pin_levels, event_valid, event_channel, event_on,
                    pulse_done, persist_valid, persist_action, last, input ready);
    modport sink (input valid, pin_levels, event_valid, event_channel, event_on,
                  pulse_done, persist_valid, persist_action, last, output ready);
endinterface

[rtl/multichannel_pulse_flash_output.sv]
`timescale 1ns / 1ps
// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    command, channel, action, channel settings
// o_out     out  valid/ready    pin levels, event, pulse done, persist, last
// Start, restore and load: accepted into a two-item queue, executed when idle
// (a no-op for an out-of-range channel), one result each. Tick: walks the
// per-channel counters, then one result per cycle while output is not stalled.
// Reset (synchronous, active low) clears pins, counters and settings.
// Output stalls hold the result register; the queue keeps accepting until full.
module multichannel_pulse_flash_output
    import mpfo_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mpfo_in_if.sink    i_in,
    mpfo_out_if.source o_out
);
`include "multichannel_pulse_flash_output_assert.svh"
    logic w_job_valid, w_job_ready;
    t_job w_job;

    mpfo_front #(.CHANNELS(CHANNELS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in),
        .o_job_valid(w_job_valid), .i_job_ready(w_job_ready), .o_job(w_job)
    );

    mpfo_back #(.CHANNELS(CHANNELS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(w_job_valid), .o_job_ready(w_job_ready), .i_job(w_job),
        .o_out(o_out)
    );

    `MPFO_ASSERT_IMP(a_full_has_job, i_clk, i_rst_n, !i_in.ready, w_job_valid)
    `MPFO_ASSERT_NXT(a_reset_quiet, i_clk, 1'b1, !i_rst_n, !o_out.valid)
    `MPFO_ASSERT_NXT(a_burst_cont, i_clk, i_rst_n, o_out.valid && o_out.ready && !o_out.last,
                     o_out.valid)
endmodule

[rtl/mpfo_front.sv]
`timescale 1ns / 1ps
module mpfo_front
    import mpfo_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mpfo_in_if.sink    i_in,
    output logic       o_job_valid,
    input  logic       i_job_ready,
    output t_job       o_job
);
    t_job       r_q [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;
    t_job       w_new;
    logic       w_push, w_pop;

    always_comb begin
        w_new.ch     = i_in.channel;
        w_new.action = i_in.action;
        w_new.cfg    = '{i_in.set_is_output, i_in.set_trigger_inv, i_in.set_pin_inv,
                         i_in.set_event_inv, i_in.set_no_off_event, i_in.set_pulse_len,
                         i_in.set_flash_half};
        if (i_in.cmd == CMD_TICK) begin
            w_new.op = OP_TICK;
        end else if (32'(i_in.channel) >= CHANNELS) begin
            w_new.op = OP_NOP;
        end else begin
            unique case (i_in.cmd)
                CMD_START:   w_new.op = OP_START;
                CMD_RESTORE: w_new.op = OP_RESTORE;
                default:     w_new.op = OP_LOAD;
            endcase
        end
    end

    assign i_in.ready  = (r_cnt != 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rptr];
    assign w_push      = i_in.valid && i_in.ready;
    assign w_pop       = o_job_valid && i_job_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_new;
        end
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) r_wptr <= !r_wptr;
            if (w_pop)  r_rptr <= !r_rptr;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

[rtl/mpfo_back.sv]
`timescale 1ns / 1ps
module mpfo_back
    import mpfo_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    output logic       o_job_ready,
    input  t_job       i_job,
    mpfo_out_if.source o_out
);
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]       r_state;
    logic [IDX_W-1:0] r_idx, r_ptr;
    logic [IDX_W:0]   r_n;
    logic [15:0]      r_pin;
    t_cfg             r_cfg [CHANNELS];
    logic [7:0]       r_pc  [CHANNELS];
    logic [7:0]       r_fc  [CHANNELS];
    t_rec             r_buf [CHANNELS];
    logic             r_out_valid;
    t_rec             r_out;
    logic [15:0]      r_out_pin;
    logic             r_out_last;

    logic             w_walk, w_go, w_free, w_emit_last, w_act;
    logic [CH_W-1:0]  w_ch;
    logic [IDX_W-1:0] w_a;
    t_cfg             w_c;
    logic [7:0]       w_f, w_p, n_f, n_p;
    logic             n_lvl, w_rec_we;
    t_rec             w_rec;

    assign w_walk = (r_state == S_WALK);
    assign w_go   = (r_state == S_IDLE) && i_job_valid;
    assign o_job_ready = (r_state == S_IDLE);
    assign w_ch   = w_walk ? CH_W'(r_idx) : i_job.ch;
    assign w_a    = w_ch[IDX_W-1:0];
    assign w_c    = r_cfg[w_a];
    assign w_f    = r_fc[w_a];
    assign w_p    = r_pc[w_a];
    assign w_act  = (i_job.action == ACT_ON) ^ w_c.trigger_inv;

    always_comb begin
        n_f      = w_f;
        n_p      = w_p;
        n_lvl    = r_pin[w_ch];
        w_rec    = '0;
        w_rec_we = 1'b0;
        if (w_walk) begin
            if (w_c.is_output) begin
                if (n_f == 8'd1) begin
                    n_lvl = w_c.pin_inv;
                    n_f   = 8'd0 - {1'b0, w_c.flash_half};
                end
                if (n_f == 8'hFF) begin
                    n_lvl = !w_c.pin_inv;
                    n_f   = {1'b0, w_c.flash_half};
                end
                if (n_f >= 8'd2 && n_f <= 8'h7F) begin
                    n_f = n_f - 8'd1;
                end else if (n_f >= 8'h80 && n_f <= 8'hFE) begin
                    n_f = n_f + 8'd1;
                end
                if (w_p == 8'd1) begin
                    n_lvl    = w_c.pin_inv;
                    w_rec_we = 1'b1;
                    w_rec.ev = !w_c.no_off_event;
                    w_rec.ch = w_ch;
                    w_rec.on = !w_c.no_off_event && w_c.event_inv;
                    w_rec.done = 1'b1;
                end
                if (w_p != 8'd0) n_p = w_p - 8'd1;
            end
        end else if (i_job.op == OP_START) begin
            if (i_job.action == ACT_FLASH) begin
                n_f   = {1'b0, w_c.flash_half};
                n_p   = 8'd0;
                n_lvl = !w_c.pin_inv;
                w_rec = '{1'b1, w_ch, !w_c.event_inv, 1'b0, 1'b1, ACT_FLASH};
            end else begin
                n_f = 8'd0;
                if (!(!w_act && w_c.pulse_len != 8'd0)) begin
                    n_lvl    = w_act ^ w_c.pin_inv;
                    w_rec.pv = 1'b1;
                    w_rec.pa = w_act ? ACT_ON : ACT_OFF;
                    if (w_act && w_c.pulse_len != 8'd0 && w_p == 8'd0) begin
                        n_p      = w_c.pulse_len;
                        w_rec.pa = ACT_OFF;
                    end
                    if (w_act || !w_c.no_off_event) begin
                        w_rec.ev = 1'b1;
                        w_rec.ch = w_ch;
                        w_rec.on = w_act ^ w_c.event_inv;
                    end
                end
            end
        end else if (i_job.op == OP_RESTORE) begin
            if (i_job.action == ACT_FLASH) begin
                n_f   = {1'b0, w_c.flash_half};
                n_lvl = 1'b1;
            end else begin
                n_lvl = (i_job.action == ACT_ON) ^ w_c.pin_inv;
            end
        end
    end

    assign w_free      = !r_out_valid || o_out.ready;
    assign w_emit_last = ({1'b0, r_ptr} == r_n - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_ptr       <= '0;
            r_n         <= '0;
            r_pin       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_cfg[i] <= '0;
                r_pc[i]  <= '0;
                r_fc[i]  <= '0;
            end
        end else begin
            if (o_out.ready && r_state != S_EMIT) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_go) begin
                        r_ptr <= '0;
                        if (i_job.op == OP_TICK) begin
                            r_idx   <= '0;
                            r_n     <= '0;
                            r_state <= S_WALK;
                        end else begin
                            if (i_job.op == OP_START || i_job.op == OP_RESTORE) begin
                                r_fc[w_a]   <= n_f;
                                r_pc[w_a]   <= n_p;
                                r_pin[w_ch] <= n_lvl;
                            end
                            if (i_job.op == OP_LOAD) r_cfg[w_a] <= i_job.cfg;
                            r_buf[0] <= w_rec;
                            r_n      <= (IDX_W+1)'(1);
                            r_state  <= S_EMIT;
                        end
                    end
                end
                S_WALK: begin
                    r_fc[w_a]   <= n_f;
                    r_pc[w_a]   <= n_p;
                    r_pin[w_ch] <= n_lvl;
                    if (w_rec_we) begin
                        r_buf[r_n[IDX_W-1:0]] <= w_rec;
                        r_n <= r_n + 1'b1;
                    end
                    if (32'(r_idx) == CHANNELS - 1) begin
                        if (r_n == '0 && !w_rec_we) begin
                            r_buf[0] <= '0;
                            r_n      <= (IDX_W+1)'(1);
                        end
                        r_state <= S_EMIT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (w_free) begin
                        r_out       <= r_buf[r_ptr];
                        r_out_pin   <= r_pin;
                        r_out_last  <= w_emit_last;
                        r_out_valid <= 1'b1;
                        if (w_emit_last) r_state <= S_IDLE;
                        else r_ptr <= r_ptr + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.pin_levels     = r_out_pin;
    assign o_out.event_valid    = r_out.ev;
    assign o_out.event_channel  = r_out.ch;
    assign o_out.event_on       = r_out.on;
    assign o_out.pulse_done     = r_out.done;
    assign o_out.persist_valid  = r_out.pv;
    assign o_out.persist_action = r_out.pa;
    assign o_out.last           = r_out_last;
endmodule
